>>> hw/rtl/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared constants and helpers for the quaternion to Euler angle pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ANGLE_BITS_DEF   = 16;
  localparam int ATAN_ENTRIES     = 24;
  localparam int SQRT_STEPS       = 24;   // result bits of the square root
  localparam int XW               = 36;   // CORDIC vector width
  localparam int RW               = 48;   // square root operand width
  localparam int IN_W             = 16;
  localparam int OUT_W            = 16;
  localparam int PITCH_LIM        = 16384;

  // atan(2^-i), full turn = 2^32
  localparam logic [31:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // CORDIC angle step in units of pi/2^(ab-1), rounded
  function automatic logic [31:0] atan_step(input int i, input int ab);
    logic [32:0] e;
    int          sh;
    sh = 32 - ab;
    if (i >= ATAN_ENTRIES) begin
      return 32'd0;
    end
    e = {1'b0, ATAN_TURN32[i]} + (33'd1 << (sh - 1));
    return 32'(e >> sh);
  endfunction

endpackage

>>> hw/rtl/quaternion_to_euler_angles_top.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top
// Unit quaternion to roll, pitch and yaw through unrolled CORDIC stages.
// ----------------------------------------------------------------------------
// Takes one quaternion per cycle and returns one result per cycle. Its stages
// in order are:
// a product stage, a sum/clamp stage, a quadrant stage, one stage per square
// root bit (24) running in parallel with the roll and yaw CORDIC stages, one
// stage per pitch CORDIC iteration, and the output register. The pipeline
// stalls as a whole when the output transfer is held off.
module quaternion_to_euler_angles_top
  import qte_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // quat_w, quat_x, quat_y, quat_z
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // roll_angle, pitch_angle, yaw_angle, pitch_clamped, zero fill
  output logic [55:0] m_axis_tdata
);

  localparam int AW = ANGLE_BITS + 3;
  localparam int WW = AW + 7;
  localparam int NT = SQRT_STEPS + CORDIC_STEPS;
  localparam int DN = (ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0;
  localparam int UP = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
  localparam logic signed [WW-1:0] RND = (DN > 0) ? (WW'(1) << (DN - 1)) : '0;
  localparam logic signed [AW-1:0] HALF_PI = AW'(1) << (ANGLE_BITS - 2);
  localparam logic signed [XW-1:0] ONE_Q30 = XW'(1) << 30;
  localparam logic signed [WW-1:0] PLIM = WW'(PITCH_LIM);

  typedef struct packed {
    logic signed [XW-1:0] roll_x;
    logic signed [XW-1:0] roll_y;
    logic signed [AW-1:0] roll_z;
    logic                 roll_zero;
    logic signed [XW-1:0] yaw_x;
    logic signed [XW-1:0] yaw_y;
    logic signed [AW-1:0] yaw_z;
    logic                 yaw_zero;
    logic [RW-1:0]        s_rem;
    logic [RW-1:0]        s_res;
    logic [RW-1:0]        c_rem;
    logic [RW-1:0]        c_res;
    logic signed [XW-1:0] p_x;
    logic signed [XW-1:0] p_y;
    logic signed [AW-1:0] p_z;
    logic                 clamped;
  } stage_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [AW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [RW-1:0] res;
  } root_t;

  function automatic vec_t cstep(input vec_t v, input int i,
                                 input logic signed [AW-1:0] a);
    vec_t                 r;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    xs = v.x >>> i;
    ys = v.y >>> i;
    if (v.y >= 0) begin
      r.x = v.x + ys;
      r.y = v.y - xs;
      r.z = v.z + a;
    end else begin
      r.x = v.x - ys;
      r.y = v.y + xs;
      r.z = v.z - a;
    end
    return r;
  endfunction

  function automatic root_t rstep(input root_t v, input logic [RW-1:0] b);
    root_t r;
    if (v.rem >= v.res + b) begin
      r.rem = v.rem - (v.res + b);
      r.res = (v.res >> 1) + b;
    end else begin
      r.rem = v.rem;
      r.res = v.res >> 1;
    end
    return r;
  endfunction

  function automatic logic signed [WW-1:0] to_out(input logic signed [WW-1:0] z);
    return ((z + RND) >>> DN) <<< UP;
  endfunction

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // valid chain
  logic          va_q, vb_q, vo_q;
  logic [NT:0]   vp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vp_q <= '0;
      vo_q <= 1'b0;
    end else if (en) begin
      va_q <= s_axis_tvalid;
      vb_q <= va_q;
      vp_q <= {vp_q[NT-1:0], vb_q};
      vo_q <= vp_q[NT];
    end
  end
  assign m_axis_tvalid = vo_q;

  // product stage
  logic signed [IN_W-1:0] qw, qx, qy, qz;
  logic signed [31:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, xz_q;

  assign qw = s_axis_tdata[15:0];
  assign qx = s_axis_tdata[31:16];
  assign qy = s_axis_tdata[47:32];
  assign qz = s_axis_tdata[63:48];

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= 32'(qw) * 32'(qx);
      yz_q <= 32'(qy) * 32'(qz);
      xx_q <= 32'(qx) * 32'(qx);
      yy_q <= 32'(qy) * 32'(qy);
      wz_q <= 32'(qw) * 32'(qz);
      xy_q <= 32'(qx) * 32'(qy);
      zz_q <= 32'(qz) * 32'(qz);
      wy_q <= 32'(qw) * 32'(qy);
      xz_q <= 32'(qx) * 32'(qz);
    end
  end

  // sum and clamp stage
  logic signed [XW-1:0] sr_d, cr_d, sy_d, cy_d, s_raw, s_cl, s_hi, s_lo;
  logic                 cl_d;
  logic signed [XW-1:0] sr_q, cr_q, sy_q, cy_q;
  logic [RW-1:0]        sv_q, cv_q;
  logic                 cl_q;

  always_comb begin
    sr_d  = (XW'(wx_q) + XW'(yz_q)) <<< 1;
    cr_d  = ONE_Q30 - ((XW'(xx_q) + XW'(yy_q)) <<< 1);
    sy_d  = (XW'(wz_q) + XW'(xy_q)) <<< 1;
    cy_d  = ONE_Q30 - ((XW'(yy_q) + XW'(zz_q)) <<< 1);
    s_raw = (XW'(wy_q) - XW'(xz_q)) <<< 1;
    cl_d  = 1'b0;
    s_cl  = s_raw;
    if (s_raw > ONE_Q30) begin
      s_cl = ONE_Q30;
      cl_d = 1'b1;
    end
    if (s_raw < -ONE_Q30) begin
      s_cl = -ONE_Q30;
      cl_d = 1'b1;
    end
    s_hi = ONE_Q30 + s_cl;
    s_lo = ONE_Q30 - s_cl;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_q <= sr_d;
      cr_q <= cr_d;
      sy_q <= sy_d;
      cy_q <= cy_d;
      sv_q <= {s_hi[31:0], 16'h0};
      cv_q <= {s_lo[31:0], 16'h0};
      cl_q <= cl_d;
    end
  end

  // quadrant stage and unrolled iterations
  stage_t pipe_d [NT+1];
  stage_t pipe_q [NT+1];

  always_comb begin
    pipe_d[0]           = '0;
    pipe_d[0].roll_zero = (sr_q == '0) && (cr_q == '0);
    pipe_d[0].yaw_zero  = (sy_q == '0) && (cy_q == '0);
    pipe_d[0].roll_x    = cr_q;
    pipe_d[0].roll_y    = sr_q;
    if (cr_q < 0) begin
      if (sr_q >= 0) begin
        pipe_d[0].roll_x = sr_q;
        pipe_d[0].roll_y = -cr_q;
        pipe_d[0].roll_z = HALF_PI;
      end else begin
        pipe_d[0].roll_x = -sr_q;
        pipe_d[0].roll_y = cr_q;
        pipe_d[0].roll_z = -HALF_PI;
      end
    end
    pipe_d[0].yaw_x = cy_q;
    pipe_d[0].yaw_y = sy_q;
    if (cy_q < 0) begin
      if (sy_q >= 0) begin
        pipe_d[0].yaw_x = sy_q;
        pipe_d[0].yaw_y = -cy_q;
        pipe_d[0].yaw_z = HALF_PI;
      end else begin
        pipe_d[0].yaw_x = -sy_q;
        pipe_d[0].yaw_y = cy_q;
        pipe_d[0].yaw_z = -HALF_PI;
      end
    end
    pipe_d[0].s_rem   = sv_q;
    pipe_d[0].c_rem   = cv_q;
    pipe_d[0].clamped = cl_q;
  end

  for (genvar t = 0; t < NT; t++) begin : g_step
    localparam logic signed [AW-1:0] A_RY = AW'(atan_step(t, ANGLE_BITS));
    localparam logic signed [AW-1:0] A_P  =
      AW'(atan_step((t >= SQRT_STEPS) ? t - SQRT_STEPS : 0, ANGLE_BITS));
    localparam logic [RW-1:0] BIT =
      (t < SQRT_STEPS) ? (RW'(1) << (RW - 2 - 2 * t)) : '0;

    always_comb begin
      vec_t  v;
      vec_t  r;
      root_t q;
      pipe_d[t+1] = pipe_q[t];
      if (t < CORDIC_STEPS) begin
        v = '{pipe_q[t].roll_x, pipe_q[t].roll_y, pipe_q[t].roll_z};
        r = cstep(v, t, A_RY);
        pipe_d[t+1].roll_x = r.x;
        pipe_d[t+1].roll_y = r.y;
        pipe_d[t+1].roll_z = r.z;
        v = '{pipe_q[t].yaw_x, pipe_q[t].yaw_y, pipe_q[t].yaw_z};
        r = cstep(v, t, A_RY);
        pipe_d[t+1].yaw_x = r.x;
        pipe_d[t+1].yaw_y = r.y;
        pipe_d[t+1].yaw_z = r.z;
      end
      if (t < SQRT_STEPS) begin
        q = rstep('{pipe_q[t].s_rem, pipe_q[t].s_res}, BIT);
        pipe_d[t+1].s_rem = q.rem;
        pipe_d[t+1].s_res = q.res;
        q = rstep('{pipe_q[t].c_rem, pipe_q[t].c_res}, BIT);
        pipe_d[t+1].c_rem = q.rem;
        pipe_d[t+1].c_res = q.res;
      end else begin
        if (t == SQRT_STEPS) begin
          v = '{XW'(pipe_q[t].c_res), XW'(pipe_q[t].s_res), AW'(0)};
        end else begin
          v = '{pipe_q[t].p_x, pipe_q[t].p_y, pipe_q[t].p_z};
        end
        r = cstep(v, t - SQRT_STEPS, A_P);
        pipe_d[t+1].p_x = r.x;
        pipe_d[t+1].p_y = r.y;
        pipe_d[t+1].p_z = r.z;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= NT; k++) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  // output conversion
  logic signed [WW-1:0] roll_w, yaw_w, pitch_w, pitch_s;
  logic [OUT_W-1:0]     roll_q, pitch_q, yaw_q;
  logic                 clamp_q;

  always_comb begin
    roll_w  = pipe_q[NT].roll_zero ? '0 : to_out(WW'(pipe_q[NT].roll_z));
    yaw_w   = pipe_q[NT].yaw_zero ? '0 : to_out(WW'(pipe_q[NT].yaw_z));
    pitch_w = to_out((WW'(pipe_q[NT].p_z) <<< 1) - WW'(HALF_PI));
    pitch_s = pitch_w;
    if (pitch_w > PLIM) begin
      pitch_s = PLIM;
    end
    if (pitch_w < -PLIM) begin
      pitch_s = -PLIM;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= roll_w[OUT_W-1:0];
      pitch_q <= pitch_s[OUT_W-1:0];
      yaw_q   <= yaw_w[OUT_W-1:0];
      clamp_q <= pipe_q[NT].clamped;
    end
  end

  assign m_axis_tdata = {7'b0, clamp_q, yaw_q, pitch_q, roll_q};

endmodule

>>> dv/quaternion_to_euler_angles_top_tb.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top_tb
// Streams quaternions into the block and checks roll, pitch, yaw and the
// clamp flag against a bit-exact angle predictor, with random gaps on both
// sides, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_top_tb;
  import qte_pkg::*;

  localparam int N_RAND    = 1850;
  localparam int LATENCY   = 4 + SQRT_STEPS + CORDIC_STEPS_DEF;
  localparam int IDLE_LIM  = 20000;
  localparam longint ONE_Q30 = 64'sd1 << 30;

  // lowest field last, matching the tdata layout
  typedef struct packed {
    logic        clamped;
    logic [15:0] yaw;
    logic [15:0] pitch;
    logic [15:0] roll;
  } angles_t;

  typedef struct {
    logic [63:0] quat;
    bit          known;
    angles_t     res;
  } vec_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;

  angles_t angles_q[$];
  int      n_err;
  int      n_sent;
  int      n_got;
  int      n_clamped;
  int      idle_cnt;
  bit      hold_off;
  bit      stim_done;

  quaternion_to_euler_angles_top dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint angle_inc(int i);
    return longint'((longint'(ATAN_TURN32[i]) + (64'sd1 << 15)) >>> 16);
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, t, nx, ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 64'sd1 << 14;
      end else begin
        x = -y; y = t; z = -(64'sd1 << 14);
      end
    end
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += angle_inc(i);
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= angle_inc(i);
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic angles_t euler_of(logic [63:0] q);
    longint w, x, y, z, sr, cr, sy, cy, s, p;
    angles_t a;
    w = longint'($signed(q[15:0]));
    x = longint'($signed(q[31:16]));
    y = longint'($signed(q[47:32]));
    z = longint'($signed(q[63:48]));
    sr = 2 * (w * x + y * z);
    cr = ONE_Q30 - 2 * (x * x + y * y);
    sy = 2 * (w * z + x * y);
    cy = ONE_Q30 - 2 * (y * y + z * z);
    s  = 2 * (w * y - x * z);
    a.clamped = 1'b0;
    if (s > ONE_Q30) begin
      s = ONE_Q30; a.clamped = 1'b1;
    end
    if (s < -ONE_Q30) begin
      s = -ONE_Q30; a.clamped = 1'b1;
    end
    p = 2 * vector_angle(int_sqrt((ONE_Q30 + s) << 16), int_sqrt((ONE_Q30 - s) << 16))
        - (64'sd1 << 14);
    if (p > PITCH_LIM) p = PITCH_LIM;
    if (p < -PITCH_LIM) p = -PITCH_LIM;
    a.roll  = 16'(vector_angle(sr, cr));
    a.yaw   = 16'(vector_angle(sy, cy));
    a.pitch = 16'(p);
    return a;
  endfunction

  function automatic logic [63:0] pack_q(int w, int x, int y, int z);
    return {16'(z), 16'(y), 16'(x), 16'(w)};
  endfunction

  // random unit-ish quaternion, occasionally scaled past unity or fully random bits
  function automatic logic [63:0] rand_quat();
    real a, b, c, d, n, k;
    int  pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return {$urandom, $urandom};
    a = real'($signed($urandom_range(0, 65535) - 32768));
    b = real'($signed($urandom_range(0, 65535) - 32768));
    c = real'($signed($urandom_range(0, 65535) - 32768));
    d = real'($signed($urandom_range(0, 65535) - 32768));
    if (pick == 1) c = a * 0.999;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n < 1.0) n = 1.0;
    k = (pick == 2) ? 32767.0 * 1.2 : 32767.0;
    return pack_q($rtoi(a / n * k * 0.99), $rtoi(b / n * k * 0.99),
                  $rtoi(c / n * k * 0.99), $rtoi(d / n * k * 0.99));
  endfunction

  task automatic send(logic [63:0] q);
    int      gap;
    angles_t e;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= q;
    e = euler_of(q);
    angles_q.push_back(e);
    n_clamped += e.clamped;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_sent++;
  endtask

  // output side
  initial begin
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(0, 12) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // checker
  always @(posedge clk_i) begin
    angles_t act, exp_a;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act = m_axis_tdata[48:0];
      n_got++;
      if (angles_q.size() == 0) begin
        $display("%0t: unexpected transfer %h", $time, m_axis_tdata);
        n_err++;
      end else begin
        exp_a = angles_q.pop_front();
        if (act.roll !== exp_a.roll) begin
          $display("%0t: roll exp %0d got %0d", $time, $signed(exp_a.roll), $signed(act.roll));
          n_err++;
        end
        if (act.pitch !== exp_a.pitch) begin
          $display("%0t: pitch exp %0d got %0d", $time, $signed(exp_a.pitch),
                   $signed(act.pitch));
          n_err++;
        end
        if (act.yaw !== exp_a.yaw) begin
          $display("%0t: yaw exp %0d got %0d", $time, $signed(exp_a.yaw), $signed(act.yaw));
          n_err++;
        end
        if (act.clamped !== exp_a.clamped) begin
          $display("%0t: clamp exp %0b got %0b", $time, exp_a.clamped, act.clamped);
          n_err++;
        end
        if (m_axis_tdata[55:49] !== 7'd0) begin
          $display("%0t: fill exp 0 got %h", $time, m_axis_tdata[55:49]);
          n_err++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || hold_off)
      idle_cnt <= 0;
    else if (rst_ni && !(stim_done && angles_q.size() == 0))
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIM) begin
      $display("quaternion_to_euler_angles_top regression: fail");
      $finish;
    end
  end

  initial begin
    vec_t dir[] = '{
      '{pack_q(32767, 0, 0, 0), 1'b1, '{1'b0, 16'd0, 16'hfffc, 16'd0}},
      '{pack_q(0, 0, 0, 0), 1'b1, '{1'b0, 16'd0, 16'hfffc, 16'd0}},
      '{pack_q(0, 32767, 0, 0), 1'b0, '0},
      '{pack_q(0, 0, 32767, 0), 1'b0, '0},
      '{pack_q(0, 0, 0, 32767), 1'b0, '0},
      '{pack_q(-32768, -32768, -32768, -32768), 1'b0, '0},
      '{pack_q(32767, 32767, 32767, 32767), 1'b0, '0},
      '{pack_q(-32768, 0, 0, 0), 1'b0, '0},
      '{pack_q(32767, 0, 32767, 0), 1'b0, '0},
      '{pack_q(32767, 0, -32768, 0), 1'b0, '0},
      '{pack_q(23170, 0, 23170, 0), 1'b0, '0},
      '{pack_q(23170, 0, -23170, 0), 1'b0, '0},
      '{pack_q(23170, 23170, 0, 0), 1'b0, '0},
      '{pack_q(23170, 0, 0, -23170), 1'b0, '0},
      '{pack_q(16384, 16384, 16384, 16384), 1'b0, '0},
      '{pack_q(16384, -16384, 16384, -16384), 1'b0, '0},
      '{pack_q(0, -32768, 0, -32768), 1'b0, '0},
      '{pack_q(1, -1, 1, -1), 1'b0, '0},
      '{pack_q(-1, 1, -1, 1), 1'b0, '0},
      '{pack_q(16'h5555, 16'haaaa, 16'h5555, 16'haaaa), 1'b0, '0}
    };
    n_err = 0; n_sent = 0; n_got = 0; n_clamped = 0; idle_cnt = 0;
    hold_off = 1'b0; stim_done = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // known rows: identity and all-zero give zero roll and yaw, pitch -4 from
    // CORDIC residue
    foreach (dir[i]) begin
      if (dir[i].known && euler_of(dir[i].quat) !== dir[i].res) begin
        $display("%0t: predictor row %0d exp %h got %h", $time, i, dir[i].res,
                 euler_of(dir[i].quat));
        n_err++;
      end
      send(dir[i].quat);
    end

    for (int i = 0; i < N_RAND; i++) begin
      if (i == 300) hold_off = 1'b1;
      if (i == 900) begin
        s_axis_tvalid <= 1'b0;
        while (angles_q.size() != 0) @(posedge clk_i);
      end
      send(rand_quat());
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;

    while (angles_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("sent %0d quaternions, %0d results checked, %0d with pitch clamped",
             n_sent, n_got, n_clamped);
    if (n_err == 0 && angles_q.size() == 0)
      $display("quaternion_to_euler_angles_top regression: pass");
    else
      $display("quaternion_to_euler_angles_top regression: fail");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/qte_pkg.sv
hw/rtl/quaternion_to_euler_angles_top.sv
dv/quaternion_to_euler_angles_top_tb.sv
